### hw/rtl/assert_macros.svh
// Assertion macros for the RTL files; included by websocket_frame_deframer.sv.
// Each macro expects a signal named clk in the scope where it is used; ASSERT_RST also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, disabled while reset is asserted.
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising edge, also while reset is asserted.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/wsdf_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package wsdf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned OPC_W   = 4;
    localparam int unsigned LIMIT_W = 32;

    localparam logic [LIMIT_W-1:0] MAX_LEN_RESET = LIMIT_W'(64 * 1024 * 1024);

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

endpackage

`default_nettype wire

### hw/rtl/wsdf_ifs.sv
// Valid/ready channel interfaces of the WebSocket frame deframer.
// Depends on wsdf_pkg for field widths and the result kind type.
`default_nettype none

interface wsdf_in_if;
    import wsdf_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsdf_out_if;
    import wsdf_pkg::*;
    logic              valid;
    logic              ready;
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [OPC_W-1:0]  opcode;
    logic              fin;
    logic              last;

    modport source (output valid, output kind, output data, output opcode,
                    output fin, output last, input ready);
    modport sink   (input valid, input kind, input data, input opcode,
                    input fin, input last, output ready);
endinterface

interface wsdf_cfg_if;
    import wsdf_pkg::*;
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] max_payload_len;

    modport source (output valid, output max_payload_len, input ready);
    modport sink   (input valid, input max_payload_len, output ready);
endinterface

`default_nettype wire

### hw/rtl/websocket_frame_deframer.sv
// WebSocket frame deframer: an accepted byte is held in the byte register, and
// its result in the result register that drives the output. Throughput is one
// byte per cycle unless a result stalls; the header/payload state update is a
// single pass per byte. A stalled result holds the byte register only when that
// byte makes a result. Reset (rst_n, async, active low) returns to the first
// header byte, clears all frame state and loads the default 64 MiB payload limit.
`default_nettype none
`include "assert_macros.svh"

module websocket_frame_deframer (
    input  wire logic clk,
    input  wire logic rst_n,
    wsdf_in_if.sink   rx,
    wsdf_out_if.source res,
    wsdf_cfg_if.sink  cfg
);
    import wsdf_pkg::*;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_EXTLEN  = 6'b000100,
        PH_MASK    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_ERROR   = 6'b100000
    } phase_t;

    // configuration
    logic [LIMIT_W-1:0] max_len_reg;

    // input byte register
    logic [BYTE_W-1:0]  byte_reg;
    logic               byte_valid_reg;

    // frame state
    phase_t             phase_reg, phase_next;
    logic [3:0]         left_reg, left_next;
    logic [31:0]        len_reg, len_next;
    logic               len_hi_reg, len_hi_next;   // length bits above 31 nonzero
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        key_reg, key_next;
    logic [1:0]         pos_reg, pos_next;
    logic [OPC_W-1:0]   opcode_reg, opcode_next;
    logic               fin_reg, fin_next;
    logic               masked_reg, masked_next;

    // result register
    logic               res_valid_reg;
    kind_t              res_kind_reg;
    logic [BYTE_W-1:0]  res_data_reg;
    logic [OPC_W-1:0]   res_opcode_reg;
    logic               res_fin_reg;
    logic               res_last_reg;

    // single-pass result of the byte in the byte register
    logic               res_valid_c;
    kind_t              res_kind_c;
    logic [BYTE_W-1:0]  res_data_c;
    logic               res_last_c;
    logic               len_done;
    logic               start_payload;
    logic [3:0]         left_dec;
    logic [31:0]        rem_dec;
    logic [BYTE_W-1:0]  key_byte;

    logic               out_free;
    logic               advance;

    assign cfg.ready = 1'b1;

    assign out_free = !res_valid_reg || res.ready;
    assign advance  = byte_valid_reg && (!res_valid_c || out_free);
    assign rx.ready = !byte_valid_reg || advance;

    assign left_dec = left_reg - 4'd1;
    assign rem_dec  = rem_reg - 32'd1;

    always_comb
    begin
        unique case (pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        left_next     = left_reg;
        len_next      = len_reg;
        len_hi_next   = len_hi_reg;
        rem_next      = rem_reg;
        key_next      = key_reg;
        pos_next      = pos_reg;
        opcode_next   = opcode_reg;
        fin_next      = fin_reg;
        masked_next   = masked_reg;
        res_valid_c   = 1'b0;
        res_kind_c    = KIND_PAYLOAD;
        res_data_c    = '0;
        res_last_c    = 1'b0;
        len_done      = 1'b0;
        start_payload = 1'b0;

        unique case (phase_reg)
            PH_HDR0:
            begin
                fin_next    = byte_reg[7];
                opcode_next = byte_reg[OPC_W-1:0];
                phase_next  = PH_HDR1;
            end
            PH_HDR1:
            begin
                masked_next = byte_reg[7];
                key_next    = '0;
                pos_next    = '0;
                len_hi_next = 1'b0;
                len_next    = '0;
                if (byte_reg[6:0] == LEN_EXT16)
                begin
                    left_next  = 4'd2;
                    phase_next = PH_EXTLEN;
                end
                else if (byte_reg[6:0] == LEN_EXT64)
                begin
                    left_next  = 4'd8;
                    phase_next = PH_EXTLEN;
                end
                else
                begin
                    len_next = {25'd0, byte_reg[6:0]};
                    len_done = 1'b1;
                end
            end
            PH_EXTLEN:
            begin
                // keep the low 32 bits; remember anything shifted past them
                len_next    = {len_reg[23:0], byte_reg};
                len_hi_next = len_hi_reg || (len_reg[31:24] != 8'd0);
                left_next   = left_dec;
                len_done    = (left_dec == 4'd0);
            end
            PH_MASK:
            begin
                key_next      = {key_reg[23:0], byte_reg};
                left_next     = left_dec;
                start_payload = (left_dec == 4'd0);
            end
            PH_PAYLOAD:
            begin
                pos_next    = pos_reg + 2'd1;
                rem_next    = rem_dec;
                res_valid_c = 1'b1;
                res_kind_c  = KIND_PAYLOAD;
                res_data_c  = byte_reg ^ key_byte;
                if (rem_dec == 32'd0)
                begin
                    res_last_c = 1'b1;
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                // error phase: drop every byte
            end
        endcase

        if (len_done)
        begin
            if (len_hi_next || (len_next > max_len_reg))
            begin
                phase_next  = PH_ERROR;
                res_valid_c = 1'b1;
                res_kind_c  = KIND_ERROR;
            end
            else if (masked_next)
            begin
                left_next  = 4'd4;
                phase_next = PH_MASK;
            end
            else
            begin
                start_payload = 1'b1;
            end
        end

        if (start_payload)
        begin
            if (len_next == 32'd0)
            begin
                phase_next  = PH_HDR0;
                res_valid_c = 1'b1;
                res_kind_c  = KIND_EMPTY;
                res_last_c  = 1'b1;
            end
            else
            begin
                rem_next   = len_next;
                pos_next   = '0;
                phase_next = PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            max_len_reg <= cfg.max_payload_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            byte_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            byte_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            left_reg   <= '0;
            len_reg    <= '0;
            len_hi_reg <= 1'b0;
            rem_reg    <= '0;
            key_reg    <= '0;
            pos_reg    <= '0;
            opcode_reg <= '0;
            fin_reg    <= 1'b0;
            masked_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            len_reg    <= len_next;
            len_hi_reg <= len_hi_next;
            rem_reg    <= rem_next;
            key_reg    <= key_next;
            pos_reg    <= pos_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            masked_reg <= masked_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance && res_valid_c)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid_c)
        begin
            res_kind_reg   <= res_kind_c;
            res_data_reg   <= res_data_c;
            res_opcode_reg <= opcode_reg;
            res_fin_reg    <= fin_reg;
            res_last_reg   <= res_last_c;
        end
    end

    assign res.valid  = res_valid_reg;
    assign res.kind   = res_kind_reg;
    assign res.data   = res_data_reg;
    assign res.opcode = res_opcode_reg;
    assign res.fin    = res_fin_reg;
    assign res.last   = res_last_reg;

    `ASSERT_RST(a_error_sticky, (phase_reg == PH_ERROR) |=> (phase_reg == PH_ERROR), "error phase left before reset")
    `ASSERT_RST(a_error_item_phase, (res_valid_reg && res_kind_reg == KIND_ERROR) |-> (phase_reg == PH_ERROR), "error item without error phase")
    `ASSERT_RST(a_payload_nonzero, (phase_reg == PH_PAYLOAD) |-> (rem_reg != 32'd0), "payload phase with nothing left")
    `ASSERT_ALWAYS(a_stall_holds_byte, (byte_valid_reg && !advance) |=> (!rst_n || byte_valid_reg), "byte register dropped while stalled")

endmodule

`default_nettype wire
